### hw/rtl/bsfs_pkg.sv
// ----------------------------------------------------------------------------
// bsfs_pkg: shared types and constants of the byte stuffing frame sender
// Holds the marker byte, the queue geometry and the command entry that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfs_pkg;

	localparam logic [7:0] MARK_BYTE = 8'h7F;

	// command queue between front end and back end
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// one bit per possible line beat of a command, in send order
	localparam int B_MARK  = 0;
	localparam int B_DDUP  = 1;
	localparam int B_DATA  = 2;
	localparam int B_CDUP  = 3;
	localparam int B_CSUM  = 4;
	localparam int B_COUNT = 5;

	typedef logic [B_COUNT-1:0] beat_mask_t;

	// classified input byte
	typedef struct packed {
		logic       open;   // frame opens here: send start marker first
		logic       last;   // frame closes here: send checksum after data
		logic [7:0] data;
		logic [7:0] csum;   // frame checksum, valid when last is set
	} cmd_t;

	// queue status seen by the two ends
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage

`default_nettype wire

### hw/rtl/byte_stuffing_frame_sender.sv
// ----------------------------------------------------------------------------
// byte_stuffing_frame_sender: framed byte sender with 0x7F stuffing and XOR
// checksum
// Turns a stream of frame bytes into the byte sequence for a serial line.
// ----------------------------------------------------------------------------
// Feed the bytes of one frame on the slave stream, length byte first, with
// s_tlast on the final byte. Before the first byte of a frame the block sends
// a 0x7F start marker; every data byte equal to 0x7F goes out twice; after the
// final byte the XOR of all the frame's bytes follows, stuffed the same way.
// Each input beat yields 1 to 5 output beats: m_tlast marks the last output
// beat caused by an input beat, and m_tuser marks the final beat of a frame
// (the last checksum beat). The output side sends one beat per cycle while
// m_tready is high, and a byte produces one beat if plain, two if stuffed,
// plus one for the marker and one or two for the checksum; the sequencer
// emitting those beats sets the sustained rate. A two-entry command queue
// sits between input and output, so the slave side keeps taking one beat per
// cycle while the queue has room, even while the output register holds a
// beat that has not been taken. The first output beat of an input byte goes
// through a queue entry and then the output register. No frame length check
// is made: the frame ends only at s_tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffing_frame_sender (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] data_byte
	input  wire        s_tlast,   // frame_last
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] line_byte
	output logic       m_tlast,   // run_last
	output logic       m_tuser    // frame_end
);
	import bsfs_pkg::*;

	q_stat_t q_stat;
	cmd_t    push_cmd;
	cmd_t    head;
	logic    push;
	logic    pop;

	// classify input bytes and keep the frame checksum
	bsfs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// hold commands so input and output stall independently
	bsfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// expand each command into line beats
	bsfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

### hw/rtl/bsfs_front.sv
// ----------------------------------------------------------------------------
// bsfs_front: input classifier
// Accepts frame bytes, tracks frame state and running XOR, and builds one
// command entry per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfs_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [7:0]       s_tdata,   // [7:0] data_byte
	input  wire              s_tlast,   // frame_last
	input  bsfs_pkg::q_stat_t q_stat,
	output logic             push,
	output bsfs_pkg::cmd_t   push_cmd
);
	import bsfs_pkg::*;

	logic [7:0] running_xor_q;
	logic       frame_open_q;
	logic [7:0] xor_next;

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	// a new frame restarts the checksum from this byte
	assign xor_next = (frame_open_q ? running_xor_q : 8'h00) ^ s_tdata;

	always_comb begin
		push_cmd.open = !frame_open_q;
		push_cmd.last = s_tlast;
		push_cmd.data = s_tdata;
		push_cmd.csum = xor_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_xor_q <= 8'h00;
			frame_open_q  <= 1'b0;
		end else if (push) begin
			if (s_tlast) begin
				running_xor_q <= 8'h00;
				frame_open_q  <= 1'b0;
			end else begin
				running_xor_q <= xor_next;
				frame_open_q  <= 1'b1;
			end
		end
	end

	closed_clears_xor: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> running_xor_q == 8'h00)
		else $error("checksum not cleared while no frame is open");

endmodule

`default_nettype wire

### hw/rtl/bsfs_queue.sv
// ----------------------------------------------------------------------------
// bsfs_queue: command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfs_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  bsfs_pkg::cmd_t    push_cmd,
	input  wire               pop,
	output bsfs_pkg::cmd_t    head,
	output bsfs_pkg::q_stat_t q_stat
);
	import bsfs_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
		ptr_inc = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
	endfunction

	assign q_stat.full  = (count_q == Q_CW'(Q_DEPTH));
	assign q_stat.valid = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CW'(1);
			end
		end
	end

	no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full && !pop))
		else $error("push into full command queue");

	no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.valid)
		else $error("pop from empty command queue");

endmodule

`default_nettype wire

### hw/rtl/bsfs_back.sv
// ----------------------------------------------------------------------------
// bsfs_back: line beat sequencer
// Expands the head command into its marker, data, stuffing and checksum
// beats, one per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfs_back (
	input  wire               clk,
	input  wire               arst_n,
	input  bsfs_pkg::cmd_t    head,
	input  bsfs_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [7:0]        m_tdata,   // [7:0] line_byte
	output logic              m_tlast,   // run_last
	output logic              m_tuser    // frame_end
);
	import bsfs_pkg::*;

	beat_mask_t mask_q;
	logic       busy_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic       m_tuser_q;

	beat_mask_t fresh_mask;
	beat_mask_t cur_mask;
	beat_mask_t low_bit;
	beat_mask_t rem_mask;
	logic       load;
	logic [7:0] beat_byte;

	always_comb begin
		fresh_mask         = '0;
		fresh_mask[B_MARK] = head.open;
		fresh_mask[B_DDUP] = (head.data == MARK_BYTE);
		fresh_mask[B_DATA] = 1'b1;
		fresh_mask[B_CDUP] = head.last && (head.csum == MARK_BYTE);
		fresh_mask[B_CSUM] = head.last;
	end

	// beats still owed by the head command; take the earliest one
	assign cur_mask = busy_q ? mask_q : fresh_mask;
	assign low_bit  = cur_mask & (~cur_mask + beat_mask_t'(1));
	assign rem_mask = cur_mask & ~low_bit;

	assign load = q_stat.valid && (!m_tvalid_q || m_tready);
	assign pop  = load && (rem_mask == '0);

	always_comb begin
		priority if (low_bit[B_MARK]) begin
			beat_byte = MARK_BYTE;
		end else if (low_bit[B_DDUP] || low_bit[B_DATA]) begin
			beat_byte = head.data;
		end else begin
			beat_byte = head.csum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			mask_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q     <= (rem_mask != '0);
				mask_q     <= rem_mask;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= beat_byte;
			m_tlast_q <= (rem_mask == '0);
			m_tuser_q <= low_bit[B_CSUM];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end beat is not the last beat of its byte");

	busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> q_stat.valid && mask_q != '0)
		else $error("sequencer busy without a pending command");

	busy_never_marks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !mask_q[B_MARK])
		else $error("start marker owed after first beat of a command");

endmodule

`default_nettype wire
